>>> rtl/core/assert_macros.svh
// assertion macros included by the sampler top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_CLK_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_CLK_NR(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/core/ics_pkg.sv
// types and constants of the inverse-cdf table sampler
`default_nettype none
package ics_pkg;

  localparam int unsigned PROB_W  = 33;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned CFG_ENTRY_COUNT = 0;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_DRAW  = 2'd1,
    KIND_TRIAL = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_FIRST,
    ST_CHK_FIRST,
    ST_CHK_LAST,
    ST_LOOP,
    ST_FETCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [PROB_W-1:0]        prob;
    logic signed [WORD_W-1:0] value;
  } entry_t;

endpackage
`default_nettype wire

>>> rtl/core/ics_if.sv
// item channel interfaces of the sampler
`default_nettype none
interface ics_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  entry_index;
  logic [32:0] entry_prob;
  logic signed [31:0] entry_value;
  logic [31:0] rand_unit;
  logic signed [31:0] rand_signed;
  logic [31:0] step;

  modport source (output valid, kind, entry_index, entry_prob, entry_value, rand_unit,
                  rand_signed, step, input ready);
  modport sink (input valid, kind, entry_index, entry_prob, entry_value, rand_unit,
                rand_signed, step, output ready);
endinterface

interface ics_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] sample;
  logic [31:0] position;
  logic [7:0]  chosen_entry;

  modport source (output valid, sample, position, chosen_entry, input ready);
  modport sink (input valid, sample, position, chosen_entry, output ready);
endinterface
`default_nettype wire

>>> rtl/core/ics_table.sv
// probability and value table memory, one write and one registered read port
`default_nettype none
module ics_table #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire ics_pkg::entry_t wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output ics_pkg::entry_t      rd_data
);

  ics_pkg::entry_t mem [DEPTH];
  ics_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

>>> rtl/core/ics_walk.sv
// random-walk offset: step times signed random value, scaled to q0.32
`default_nettype none
module ics_walk (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire logic [31:0]        step,
  input  wire logic signed [31:0] rand_signed,
  output logic [31:0]             offset
);

  logic [31:0]        step_r;
  logic signed [31:0] rand_r;
  logic signed [54:0] full;
  logic [54:0]        prod_r;

  always_ff @(posedge clk) begin
    if (load) begin
      step_r <= step;
      rand_r <= rand_signed;
    end
  end

  assign full = 55'($signed({1'b0, step_r})) * 55'(rand_r);

  always_ff @(posedge clk) begin
    prod_r <= full;
  end

  // floor shift by 23, low word only
  assign offset = prod_r[54:23];

endmodule
`default_nettype wire

>>> rtl/core/inverse_cdf_table_sampler.sv
// top level of the inverse-cdf table sampler
//
// channel   | direction | handshake                  | payload
// in_item   | in        | valid/ready                | kind, entry, random operands
// out_item  | out       | valid/ready                | sample, position, chosen_entry
// apb       | in        | psel/penable/pwrite, pready | entry_count at byte 0
//
// a load item is taken in idle and the sequencer stays idle; a draw reads the
// first probability and ends if the position is at or below it, then the last,
// ending if at or beyond it, else searches in at most floor(log2(n))+1 steps for
// n entries in use, then fetches the entry; a trial first multiplies and adds.
// each search step is one read of the single table read port.
// reset is synchronous; position and entry_count clear to 0 and 1.
// a result waits in the output register while the next item is taken.
`default_nettype none
`include "assert_macros.svh"
module inverse_cdf_table_sampler #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ics_in_if.sink           in_item,
  ics_out_if.source        out_item,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned N_W   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SUM_W = N_W + 1;

  ics_pkg::state_t state_r, state_nxt;

  logic [ics_pkg::CNT_W-1:0] cnt_r;
  logic [31:0]               pos_r, pos_nxt;
  logic [N_W-1:0]            lo_r, lo_nxt, hi_r, hi_nxt;
  logic [IDX_W-1:0]          mid_r, mid_nxt, sel_r, sel_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [31:0]        out_sample_r;
  logic [31:0]               out_pos_r;
  logic [7:0]                out_idx_r;
  logic                      out_load;

  logic [N_W-1:0]            n;
  logic [IDX_W-1:0]          last;
  logic [N_W-1:0]            lo_cmp, hi_cmp;
  logic [SUM_W-1:0]          sum;

  logic                      in_ready;
  logic                      walk_load;
  logic [31:0]               offset;
  logic                      wr_en, rd_en;
  logic [IDX_W-1:0]          rd_addr;
  ics_pkg::entry_t           wr_data, rd_data;
  logic                      cfg_wr;

  // configuration
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == 1'(ics_pkg::CFG_ENTRY_COUNT));
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'(ics_pkg::CFG_ENTRY_COUNT)) ? 32'(cnt_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= ics_pkg::CNT_W'(1);
    end else if (cfg_wr) begin
      cnt_r <= pwdata[ics_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    if (cnt_r == '0) begin
      n = N_W'(1);
    end else if (32'(cnt_r) > TABLE_DEPTH) begin
      n = N_W'(TABLE_DEPTH);
    end else begin
      n = N_W'(cnt_r);
    end
  end

  assign last = IDX_W'(n - N_W'(1));

  // table memory
  assign wr_en = in_item.valid && in_ready &&
                 (in_item.kind == ics_pkg::KIND_LOAD) &&
                 (32'(in_item.entry_index) < TABLE_DEPTH);
  assign wr_data.prob  = in_item.entry_prob;
  assign wr_data.value = in_item.entry_value;

  ics_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(in_item.entry_index)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ics_walk u_walk (
    .clk         (clk),
    .load        (walk_load),
    .step        (in_item.step),
    .rand_signed (in_item.rand_signed),
    .offset      (offset)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ics_pkg::ST_IDLE;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    sel_r <= sel_nxt;
    if (out_load) begin
      out_sample_r <= rd_data.value;
      out_pos_r    <= pos_r;
      out_idx_r    <= 8'(sel_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    sel_nxt   = sel_r;
    in_ready  = 1'b0;
    walk_load = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    out_load  = 1'b0;
    lo_cmp    = lo_r;
    hi_cmp    = hi_r;
    sum       = '0;
    out_valid_nxt = out_valid_r && !out_item.ready;

    case (state_r)
      ics_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_item.valid) begin
          case (ics_pkg::kind_t'(in_item.kind))
            ics_pkg::KIND_DRAW: begin
              pos_nxt   = in_item.rand_unit;
              state_nxt = ics_pkg::ST_FIRST;
            end
            ics_pkg::KIND_TRIAL: begin
              walk_load = 1'b1;
              state_nxt = ics_pkg::ST_MUL;
            end
            default: begin
              state_nxt = ics_pkg::ST_IDLE;
            end
          endcase
        end
      end
      ics_pkg::ST_MUL: begin
        state_nxt = ics_pkg::ST_ADD;
      end
      ics_pkg::ST_ADD: begin
        pos_nxt   = pos_r + offset;
        state_nxt = ics_pkg::ST_FIRST;
      end
      ics_pkg::ST_FIRST: begin
        rd_en     = 1'b1;
        rd_addr   = '0;
        state_nxt = ics_pkg::ST_CHK_FIRST;
      end
      ics_pkg::ST_CHK_FIRST: begin
        if ({1'b0, pos_r} <= rd_data.prob) begin
          sel_nxt   = '0;
          state_nxt = ics_pkg::ST_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = last;
          state_nxt = ics_pkg::ST_CHK_LAST;
        end
      end
      ics_pkg::ST_CHK_LAST: begin
        if ({1'b0, pos_r} >= rd_data.prob) begin
          sel_nxt   = last;
          state_nxt = ics_pkg::ST_DONE;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = n;
          mid_nxt   = IDX_W'(n >> 1);
          rd_en     = 1'b1;
          rd_addr   = IDX_W'(n >> 1);
          state_nxt = ics_pkg::ST_LOOP;
        end
      end
      ics_pkg::ST_LOOP: begin
        if ({1'b0, pos_r} < rd_data.prob) begin
          lo_cmp = lo_r;
          hi_cmp = N_W'(mid_r);
        end else begin
          lo_cmp = N_W'(mid_r) + N_W'(1);
          hi_cmp = hi_r;
        end
        lo_nxt = lo_cmp;
        hi_nxt = hi_cmp;
        sum    = SUM_W'(lo_cmp) + SUM_W'(hi_cmp);
        rd_en  = 1'b1;
        if (lo_cmp < hi_cmp) begin
          mid_nxt = IDX_W'(sum >> 1);
          rd_addr = IDX_W'(sum >> 1);
        end else begin
          sel_nxt   = (lo_cmp == '0) ? '0 : IDX_W'(lo_cmp - N_W'(1));
          rd_addr   = (lo_cmp == '0) ? '0 : IDX_W'(lo_cmp - N_W'(1));
          state_nxt = ics_pkg::ST_FETCH;
        end
      end
      ics_pkg::ST_FETCH: begin
        state_nxt = ics_pkg::ST_DONE;
      end
      ics_pkg::ST_DONE: begin
        if (!out_valid_r || out_item.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ics_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ics_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_item.ready         = in_ready;
  assign out_item.valid        = out_valid_r;
  assign out_item.sample       = out_sample_r;
  assign out_item.position     = out_pos_r;
  assign out_item.chosen_entry = out_idx_r;

  `ASSERT_CLK(a_out_from_done, clk, rst_n, $rose(out_item.valid) |-> $past(state_r == ics_pkg::ST_DONE), "result without completed search")
  `ASSERT_CLK(a_loop_bounds, clk, rst_n, (state_r == ics_pkg::ST_LOOP) |-> (lo_r < hi_r) && (hi_r <= n), "search bounds collapsed")
  `ASSERT_CLK(a_load_no_work, clk, rst_n, (in_item.valid && in_ready && in_item.kind == ics_pkg::KIND_LOAD) |=> (state_r == ics_pkg::ST_IDLE), "load item started a search")
  `ASSERT_CLK_NR(a_reset_empty, clk, !rst_n |=> !out_item.valid, "result pending after reset")

endmodule
`default_nettype wire
